@@ src/u8u16_pkg.sv @@
package u8u16_pkg;

    // field widths
    localparam int ByteW  = 8;
    localparam int UnitW  = 16;
    localparam int CountW = 10;
    localparam int PointW = 21;
    localparam int DueW   = 2;

    // register reset value
    localparam logic [CountW-1:0] MaxUnitsReset = 10'd255;

    // utf-16 constants
    localparam logic [PointW-1:0] SuppBase = 21'h10000;
    localparam logic [UnitW-1:0]  HighSurr = 16'hD800;
    localparam logic [UnitW-1:0]  LowSurr  = 16'hDC00;

    // result kinds
    typedef enum logic [1:0] {
        KIND_UNIT      = 2'd0,
        KIND_DONE      = 2'd1,
        KIND_MALFORMED = 2'd2,
        KIND_OVERFLOW  = 2'd3
    } t_kind;

    // per-string decode state
    typedef struct packed {
        logic [PointW-1:0] partial;
        logic [DueW-1:0]   due;
        logic [CountW-1:0] units;
        logic              skipping;
    } t_state;

    // one result word
    typedef struct packed {
        logic              last;
        logic [CountW-1:0] unit_count;
        t_kind             kind;
        logic [UnitW-1:0]  code_unit;
    } t_result;

endpackage

@@ src/u8u16_step.sv @@
module u8u16_step (
    input  u8u16_pkg::t_state             i_st,
    input  logic [u8u16_pkg::ByteW-1:0]   i_byte,
    input  logic [u8u16_pkg::CountW-1:0]  i_max_units,
    output u8u16_pkg::t_state             o_st,
    output logic [1:0]                    o_num,
    output u8u16_pkg::t_result            o_res0,
    output u8u16_pkg::t_result            o_res1
);
    import u8u16_pkg::*;

    logic              do_emit;
    logic [PointW-1:0] emit_cp;
    logic              do_status;
    t_kind             st_kind;
    logic              st_skip;
    logic [PointW-1:0] shifted;
    logic [PointW-1:0] supp;
    logic [CountW:0]   units_plus2;

    assign shifted     = {i_st.partial[PointW-7:0], i_byte[5:0]};
    assign supp        = emit_cp - SuppBase;
    assign units_plus2 = {1'b0, i_st.units} + 11'd2;

    // decode one byte against the current state
    always_comb begin
        o_st      = i_st;
        o_num     = 2'd0;
        o_res0    = '0;
        o_res1    = '0;
        do_emit   = 1'b0;
        emit_cp   = '0;
        do_status = 1'b0;
        st_kind   = KIND_DONE;
        st_skip   = 1'b0;

        // classify the byte
        if (i_st.skipping) begin
            if (i_byte == 8'h00) begin
                o_st.skipping = 1'b0;
            end
        end else if (i_st.due != 2'd0) begin
            if (i_byte[7:6] != 2'b10) begin
                do_status = 1'b1;
                st_kind   = KIND_MALFORMED;
                st_skip   = (i_byte != 8'h00);
            end else begin
                o_st.partial = shifted;
                o_st.due     = i_st.due - 2'd1;
                if (i_st.due == 2'd1) begin
                    do_emit      = 1'b1;
                    emit_cp      = shifted;
                    o_st.partial = '0;
                end
            end
        end else if (i_byte == 8'h00) begin
            do_status = 1'b1;
            st_kind   = KIND_DONE;
        end else if (i_byte[7] == 1'b0) begin
            do_emit = 1'b1;
            emit_cp = {13'd0, i_byte};
        end else if (i_byte[7:5] == 3'b110) begin
            o_st.partial = {16'd0, i_byte[4:0]};
            o_st.due     = 2'd1;
        end else if (i_byte[7:4] == 4'b1110) begin
            o_st.partial = {17'd0, i_byte[3:0]};
            o_st.due     = 2'd2;
        end else if (i_byte[7:3] == 5'b11110) begin
            o_st.partial = {18'd0, i_byte[2:0]};
            o_st.due     = 2'd3;
        end else begin
            do_status = 1'b1;
            st_kind   = KIND_MALFORMED;
            st_skip   = 1'b1;
        end

        // finished code point: one unit, a surrogate pair, or an overflow status when max_units would be exceeded
        if (do_emit) begin
            if (emit_cp < SuppBase) begin
                if (i_st.units >= i_max_units) begin
                    do_status = 1'b1;
                    st_kind   = KIND_OVERFLOW;
                    st_skip   = 1'b1;
                end else begin
                    o_st.units        = i_st.units + 10'd1;
                    o_num             = 2'd1;
                    o_res0.code_unit  = emit_cp[UnitW-1:0];
                    o_res0.kind       = KIND_UNIT;
                    o_res0.unit_count = i_st.units + 10'd1;
                    o_res0.last       = 1'b1;
                end
            end else if (units_plus2 > {1'b0, i_max_units}) begin
                do_status = 1'b1;
                st_kind   = KIND_OVERFLOW;
                st_skip   = 1'b1;
            end else begin
                o_st.units        = units_plus2[CountW-1:0];
                o_num             = 2'd2;
                o_res0.code_unit  = HighSurr + {5'd0, supp[20:10]};
                o_res0.kind       = KIND_UNIT;
                o_res0.unit_count = i_st.units + 10'd1;
                o_res0.last       = 1'b0;
                o_res1.code_unit  = LowSurr | {6'd0, supp[9:0]};
                o_res1.kind       = KIND_UNIT;
                o_res1.unit_count = units_plus2[CountW-1:0];
                o_res1.last       = 1'b1;
            end
        end

        // status ends the string
        if (do_status) begin
            o_num             = 2'd1;
            o_res0            = '0;
            o_res0.kind       = st_kind;
            o_res0.unit_count = i_st.units;
            o_res0.last       = 1'b1;
            o_st.partial      = '0;
            o_st.due          = '0;
            o_st.units        = '0;
            o_st.skipping     = st_skip;
        end
    end

endmodule

@@ src/utf8_to_utf16_transcoder_core.sv @@
// a result word is written into the result queue when its byte is accepted; m_axis shows the queue head
// one byte per cycle while s_axis_tready is high; a surrogate pair gives two words, high then low
// a four-word result queue sits between decode and m_axis; s_axis_tready is high
// while the queue holds two words or fewer, so a byte can always place both results
// reset (synchronous, active low) clears string state and queue, max_units goes to 255
module utf8_to_utf16_transcoder_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [u8u16_pkg::CountW-1:0]  i_cfg_wdata,    // max_units
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,   // [7:0] text_byte
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [31:0]                   m_axis_tdata,   // [15:0] code_unit, [25:16] unit_count
    output logic [1:0]                    m_axis_tuser,   // [1:0] kind
    output logic                          m_axis_tlast    // run_last
);
    import u8u16_pkg::*;

    localparam int QDepth = 4;
    localparam int QPtrW  = 2;

    logic [CountW-1:0] r_max_units;
    t_state            r_st;
    t_state            n_st;
    logic [1:0]        step_num;
    t_result           step_res0;
    t_result           step_res1;
    t_result           r_queue [QDepth];
    logic [QPtrW-1:0]  r_wr_ptr;
    logic [QPtrW-1:0]  r_rd_ptr;
    logic [QPtrW:0]    r_count;
    logic [QPtrW:0]    n_count;
    logic              in_acc;
    logic              out_acc;
    logic [1:0]        push_num;
    t_result           head;

    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign out_acc  = m_axis_tvalid && m_axis_tready;
    assign push_num = in_acc ? step_num : 2'd0;

    // per-byte decode
    u8u16_step u_step (
        .i_st        (r_st),
        .i_byte      (s_axis_tdata),
        .i_max_units (r_max_units),
        .o_st        (n_st),
        .o_num       (step_num),
        .o_res0      (step_res0),
        .o_res1      (step_res1)
    );

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_units <= MaxUnitsReset;
        end else if (i_cfg_we) begin
            r_max_units <= i_cfg_wdata;
        end
    end

    // string state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '0;
        end else if (in_acc) begin
            r_st <= n_st;
        end
    end

    // result queue pointers and fill count
    assign n_count = r_count + {1'b0, push_num} - {2'd0, out_acc};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + push_num;
            r_rd_ptr <= r_rd_ptr + {1'b0, out_acc};
            r_count  <= n_count;
        end
    end

    // result queue storage
    always_ff @(posedge i_clk) begin
        if (push_num != 2'd0) begin
            r_queue[r_wr_ptr] <= step_res0;
        end
        if (push_num == 2'd2) begin
            r_queue[r_wr_ptr + 2'd1] <= step_res1;
        end
    end

    // output side
    assign head          = r_queue[r_rd_ptr];
    assign s_axis_tready = (r_count <= 3'd2);
    assign m_axis_tvalid = (r_count != 3'd0);
    assign m_axis_tdata  = {6'd0, head.unit_count, head.code_unit};
    assign m_axis_tuser  = head.kind;
    assign m_axis_tlast  = head.last;

    // queue never overfills
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 3'd4)
        else $error("result queue overfilled");

    // status words carry no code unit
    a_status_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser != KIND_UNIT) |-> (m_axis_tdata[15:0] == 16'd0))
        else $error("status word with nonzero code unit");

    // every status closes its byte's results
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser != KIND_UNIT) |-> m_axis_tlast)
        else $error("status word not marked last");

    // skipping never coexists with a pending sequence or a nonzero unit count
    a_skip_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.skipping |-> (r_st.due == 2'd0 && r_st.units == '0))
        else $error("skipping with string state left over");

endmodule
